/* hdl/lfu_pkg.sv */
// shared types, constants and state codes for the lfu cache policy unit
// no dependencies
package lfu_pkg;

  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int COUNT_W    = 32;
  localparam int STAMP_W    = 64;
  localparam int CAP_W      = 5;
  localparam int ENTRIES_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [VAL_W-1:0] READ_MISS = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 32'd1;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

endpackage

/* hdl/lfu_store.sv */
// entry memory: one write port, one registered read port
// depends on lfu_pkg for the entry record type
module lfu_store #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  lfu_pkg::entry_t     wr_data,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output lfu_pkg::entry_t     rd_data
);

  lfu_pkg::entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/lfu_cmp.sv */
// victim compare: lower use count wins, then older stamp
// depends on lfu_pkg for field widths
module lfu_cmp (
  input  logic [lfu_pkg::COUNT_W-1:0] cand_count,
  input  logic [lfu_pkg::STAMP_W-1:0] cand_stamp,
  input  logic [lfu_pkg::COUNT_W-1:0] best_count,
  input  logic [lfu_pkg::STAMP_W-1:0] best_stamp,
  output logic                        cand_less
);

  assign cand_less = {cand_count, cand_stamp} < {best_count, best_stamp};

endmodule

/* hdl/lfu_cache_policy_unit.sv */
// top level of the lfu cache policy unit: sequencer, scan registers, config
// depends on lfu_pkg, lfu_store and lfu_cmp
//
// usage:
//   commands enter on in_kind/in_key/in_value, taken at an edge where start is
//   high and busy is low. kind get looks a key up, kind put inserts or updates.
//   each command gives exactly one result on out_* marked by out_valid for one
//   cycle; the receiver cannot stall, so the result must be taken then.
//   each command reads every entry of the memory once through its single read
//   port; an entry is checked in the cycle after its read for a key match and a
//   free slot, and through the single compare unit for the eviction victim. a
//   closing scan step follows, then the commit state writes the chosen entry
//   back. busy is low again in the out_valid cycle, so the next command can be
//   taken in that cycle. capacity is written on cfg_valid/cfg_ready (always
//   ready); the user must do so only while idle; the unit does not check it.
//   after reset the unit clears the valid flag of every entry, one per cycle,
//   with busy high; capacity resets to 16.
module lfu_cache_policy_unit #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_kind,
  input  logic signed [31:0]          in_key,
  input  logic signed [31:0]          in_value,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic signed [31:0]          out_read_value,
  output logic                        out_evicted,
  output logic signed [31:0]          out_evicted_key,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]   cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lfu_pkg::CAP_W) ? CNT_W : lfu_pkg::CAP_W;

  lfu_pkg::state_t state_r, state_nxt;

  logic [lfu_pkg::CAP_W-1:0]   capacity_r;
  logic [CNT_W-1:0]            used_r, used_nxt;
  logic [lfu_pkg::STAMP_W-1:0] clock_r, clock_nxt;
  logic [IDX_W-1:0]            clr_idx_r, clr_idx_nxt;

  logic                        kind_r, kind_nxt;
  logic [31:0]                 key_r, key_nxt;
  logic [31:0]                 value_r, value_nxt;

  logic [CNT_W-1:0]            issue_r, issue_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]            chk_idx_r, chk_idx_nxt;

  logic                        match_r, match_nxt;
  logic [IDX_W-1:0]            match_idx_r, match_idx_nxt;
  logic [31:0]                 match_val_r, match_val_nxt;
  logic [lfu_pkg::COUNT_W-1:0] match_cnt_r, match_cnt_nxt;
  logic                        free_r, free_nxt;
  logic [IDX_W-1:0]            free_idx_r, free_idx_nxt;
  logic                        vic_r, vic_nxt;
  logic [IDX_W-1:0]            vic_idx_r, vic_idx_nxt;
  logic [lfu_pkg::COUNT_W-1:0] vic_cnt_r, vic_cnt_nxt;
  logic [lfu_pkg::STAMP_W-1:0] vic_stamp_r, vic_stamp_nxt;
  logic [31:0]                 vic_key_r, vic_key_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_hit_r, out_hit_nxt;
  logic [31:0]                 out_rv_r, out_rv_nxt;
  logic                        out_ev_r, out_ev_nxt;
  logic [31:0]                 out_evk_r, out_evk_nxt;

  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  lfu_pkg::entry_t             wr_data;
  logic                        rd_en;
  lfu_pkg::entry_t             rd_data;
  logic                        cand_less;

  logic                        accept;
  logic                        scan_done;
  logic [CMP_W-1:0]            cap_ext, ent_ext, used_ext, cap_eff;
  logic                        use_free;
  logic [lfu_pkg::COUNT_W-1:0] cnt_inc;

  assign accept    = start && (state_r == lfu_pkg::ST_IDLE);
  assign busy      = (state_r != lfu_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign scan_done = (issue_r == CNT_W'(ENTRIES)) && !chk_vld_r;

  assign cap_ext  = CMP_W'(capacity_r);
  assign ent_ext  = CMP_W'(ENTRIES);
  assign used_ext = CMP_W'(used_r);
  assign cap_eff  = (cap_ext > ent_ext) ? ent_ext : cap_ext;
  assign use_free = (used_ext < cap_eff) && free_r;
  assign cnt_inc  = (match_cnt_r == '1) ? match_cnt_r : match_cnt_r + lfu_pkg::COUNT_ONE;

  assign rd_en = (state_r == lfu_pkg::ST_SCAN) && (issue_r < CNT_W'(ENTRIES));

  lfu_store #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (issue_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  lfu_cmp u_cmp (
    .cand_count (rd_data.count),
    .cand_stamp (rd_data.stamp),
    .best_count (vic_cnt_r),
    .best_stamp (vic_stamp_r),
    .cand_less  (cand_less)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfu_pkg::ST_CLEAR: begin
        if (clr_idx_r == IDX_W'(ENTRIES - 1)) state_nxt = lfu_pkg::ST_IDLE;
      end
      lfu_pkg::ST_IDLE: begin
        if (start) state_nxt = lfu_pkg::ST_SCAN;
      end
      lfu_pkg::ST_SCAN: begin
        if (scan_done) state_nxt = lfu_pkg::ST_COMMIT;
      end
      lfu_pkg::ST_COMMIT: begin
        state_nxt = lfu_pkg::ST_IDLE;
      end
      default: state_nxt = lfu_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    used_nxt      = used_r;
    clock_nxt     = clock_r;
    clr_idx_nxt   = clr_idx_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    issue_nxt     = issue_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    match_val_nxt = match_val_r;
    match_cnt_nxt = match_cnt_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    vic_nxt       = vic_r;
    vic_idx_nxt   = vic_idx_r;
    vic_cnt_nxt   = vic_cnt_r;
    vic_stamp_nxt = vic_stamp_r;
    vic_key_nxt   = vic_key_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = out_hit_r;
    out_rv_nxt    = out_rv_r;
    out_ev_nxt    = out_ev_r;
    out_evk_nxt   = out_evk_r;
    wr_en         = 1'b0;
    wr_addr       = clr_idx_r;
    wr_data       = '0;

    unique case (state_r)
      lfu_pkg::ST_CLEAR: begin
        wr_en       = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      lfu_pkg::ST_IDLE: begin
        if (accept) begin
          kind_nxt  = in_kind;
          key_nxt   = in_key;
          value_nxt = in_value;
          issue_nxt = '0;
          match_nxt = 1'b0;
          free_nxt  = 1'b0;
          vic_nxt   = 1'b0;
        end
      end
      lfu_pkg::ST_SCAN: begin
        if (rd_en) begin
          issue_nxt   = issue_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = issue_r[IDX_W-1:0];
        end
        // entry read last cycle is checked now
        if (chk_vld_r) begin
          if (rd_data.valid) begin
            if (!match_r && rd_data.key == key_r) begin
              match_nxt     = 1'b1;
              match_idx_nxt = chk_idx_r;
              match_val_nxt = rd_data.value;
              match_cnt_nxt = rd_data.count;
            end
            if (!vic_r || cand_less) begin
              vic_nxt       = 1'b1;
              vic_idx_nxt   = chk_idx_r;
              vic_cnt_nxt   = rd_data.count;
              vic_stamp_nxt = rd_data.stamp;
              vic_key_nxt   = rd_data.key;
            end
          end else if (!free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
        end
      end
      lfu_pkg::ST_COMMIT: begin
        out_valid_nxt = 1'b1;
        out_hit_nxt   = match_r;
        out_rv_nxt    = match_r ? match_val_r : lfu_pkg::READ_MISS;
        out_ev_nxt    = 1'b0;
        out_evk_nxt   = '0;
        wr_data.valid = 1'b1;
        wr_data.key   = key_r;
        wr_data.stamp = clock_r;
        if (match_r && (kind_r == lfu_pkg::KIND_GET || cap_eff != '0)) begin
          // use of a present key
          wr_en         = 1'b1;
          wr_addr       = match_idx_r;
          wr_data.value = (kind_r == lfu_pkg::KIND_PUT) ? value_r : match_val_r;
          wr_data.count = cnt_inc;
          clock_nxt     = clock_r + 1'b1;
          out_rv_nxt    = wr_data.value;
        end else if (!match_r && kind_r == lfu_pkg::KIND_PUT && cap_eff != '0) begin
          wr_en         = 1'b1;
          wr_data.value = value_r;
          wr_data.count = lfu_pkg::COUNT_ONE;
          clock_nxt     = clock_r + 1'b1;
          out_rv_nxt    = value_r;
          if (use_free) begin
            wr_addr  = free_idx_r;
            used_nxt = used_r + 1'b1;
          end else if (vic_r) begin
            wr_addr     = vic_idx_r;
            out_ev_nxt  = 1'b1;
            out_evk_nxt = vic_key_r;
          end else begin
            wr_addr  = '0;
            used_nxt = used_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfu_pkg::ST_CLEAR;
      capacity_r  <= lfu_pkg::CAP_RESET;
      used_r      <= '0;
      clock_r     <= '0;
      clr_idx_r   <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      clock_r     <= clock_nxt;
      clr_idx_r   <= clr_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    value_r     <= value_nxt;
    issue_r     <= issue_nxt;
    chk_idx_r   <= chk_idx_nxt;
    match_r     <= match_nxt;
    match_idx_r <= match_idx_nxt;
    match_val_r <= match_val_nxt;
    match_cnt_r <= match_cnt_nxt;
    free_r      <= free_nxt;
    free_idx_r  <= free_idx_nxt;
    vic_r       <= vic_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_cnt_r   <= vic_cnt_nxt;
    vic_stamp_r <= vic_stamp_nxt;
    vic_key_r   <= vic_key_nxt;
    out_hit_r   <= out_hit_nxt;
    out_rv_r    <= out_rv_nxt;
    out_ev_r    <= out_ev_nxt;
    out_evk_r   <= out_evk_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_rv_r;
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_evk_r;

endmodule
